### rtl/core/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg: version string compare shared definitions
// Byte classes, class-machine states, comparison phases, first-difference
// actions and the per-pair record passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		BC_OTHER = 2'd0,
		BC_DIGIT = 2'd1,
		BC_ZERO  = 2'd2
	} byte_class_t;

	typedef enum logic [1:0] {
		CS_NORMAL   = 2'd0,
		CS_INTEGER  = 2'd1,
		CS_FRACTION = 2'd2,
		CS_LEADZ    = 2'd3
	} class_state_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CMP  = 2'd1,
		PH_LEN  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ACT_MINUS = 2'd0,
		ACT_PLUS  = 2'd1,
		ACT_CMP   = 2'd2,
		ACT_LEN   = 2'd3
	} action_t;

	typedef struct packed {
		logic               start;
		logic               a_zero;
		byte_class_t        cls_a;
		byte_class_t        cls_b;
		logic signed [8:0]  diff;
	} pair_info_t;

	function automatic byte_class_t classify(input logic [7:0] c);
		byte_class_t r;
		if (c == CHAR_ZERO) begin
			r = BC_ZERO;
		end else if (c > CHAR_ZERO && c <= CHAR_NINE) begin
			r = BC_DIGIT;
		end else begin
			r = BC_OTHER;
		end
		return r;
	endfunction

	function automatic class_state_t next_class(input class_state_t cs, input byte_class_t bc);
		class_state_t r;
		unique case (bc)
			BC_DIGIT: begin
				unique case (cs)
					CS_NORMAL, CS_INTEGER: r = CS_INTEGER;
					default:               r = CS_FRACTION;
				endcase
			end
			BC_ZERO: begin
				unique case (cs)
					CS_NORMAL: r = CS_LEADZ;
					default:   r = cs;
				endcase
			end
			default: r = CS_NORMAL;
		endcase
		return r;
	endfunction

	function automatic action_t diff_action(input class_state_t cs, input byte_class_t ca,
		input byte_class_t cb);
		action_t r;
		logic    da;
		logic    db;
		da = (ca != BC_OTHER);
		db = (cb != BC_OTHER);
		r  = ACT_CMP;
		unique case (cs)
			CS_NORMAL: begin
				if (ca == BC_DIGIT && cb == BC_DIGIT) begin
					r = ACT_LEN;
				end
			end
			CS_INTEGER: begin
				if (da && db) begin
					r = ACT_LEN;
				end else if (da) begin
					r = ACT_PLUS;
				end else if (db) begin
					r = ACT_MINUS;
				end
			end
			CS_LEADZ: begin
				if (da && !db) begin
					r = ACT_MINUS;
				end else if (!da && db) begin
					r = ACT_PLUS;
				end
			end
			default: r = ACT_CMP;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/vsc_in_if.sv
// ----------------------------------------------------------------------------
// vsc_in_if: byte pair channel
// Valid/ready channel carrying one aligned byte pair and the start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic       start_pair;

	modport source(output valid, output byte_a, output byte_b, output start_pair, input ready);
	modport sink(input valid, input byte_a, input byte_b, input start_pair, output ready);
endinterface

`default_nettype wire

### rtl/core/vsc_out_if.sv
// ----------------------------------------------------------------------------
// vsc_out_if: comparison result channel
// Valid/ready channel carrying one signed order value per comparison.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsc_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] order;

	modport source(output valid, output order, input ready);
	modport sink(input valid, input order, output ready);
endinterface

`default_nettype wire

### rtl/core/vsc_front.sv
// ----------------------------------------------------------------------------
// vsc_front: pair classifier
// Accepts byte pairs, classes both bytes, forms the byte difference and
// pushes the record into the pair queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_front
	import vsc_pkg::*;
(
	vsc_in_if.sink      pair_ch,
	input  wire logic   queue_full,
	output logic        push,
	output pair_info_t  push_info
);

	assign pair_ch.ready = !queue_full;
	assign push          = pair_ch.valid && !queue_full;

	always_comb begin
		push_info.start  = pair_ch.start_pair;
		push_info.a_zero = (pair_ch.byte_a == 8'h00);
		push_info.cls_a  = classify(pair_ch.byte_a);
		push_info.cls_b  = classify(pair_ch.byte_b);
		push_info.diff   = $signed({1'b0, pair_ch.byte_a}) - $signed({1'b0, pair_ch.byte_b});
	end

endmodule

`default_nettype wire

### rtl/core/vsc_queue.sv
// ----------------------------------------------------------------------------
// vsc_queue: pair queue
// Short FIFO of classified pairs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_queue
	import vsc_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire pair_info_t  push_info,
	output logic             full,
	input  wire logic        pop,
	output pair_info_t       pop_info,
	output logic             not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pair_info_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_info  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("pair queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pair queue popped while empty");
`endif

endmodule

`default_nettype wire

### rtl/core/vsc_back.sv
// ----------------------------------------------------------------------------
// vsc_back: comparison engine
// Runs the class machine and digit-run length phase on queued pairs and
// holds each result in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_back
	import vsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire pair_info_t  item,
	output logic             pop,
	vsc_out_if.source        order_ch
);

	phase_t             phase_q;
	phase_t             phase_d;
	class_state_t       class_q;
	class_state_t       class_d;
	logic signed [8:0]  saved_diff_q;
	logic               order_valid_q;
	logic signed [8:0]  order_q;

	phase_t             ph_eff;
	class_state_t       cs_eff;
	action_t            act;
	logic               da;
	logic               db;
	logic               emit;
	logic signed [8:0]  emit_value;
	logic               save_diff;

	assign pop = item_valid && (!order_valid_q || order_ch.ready);

	assign ph_eff = item.start ? PH_CMP : phase_q;
	assign cs_eff = item.start ? CS_NORMAL : class_q;
	assign act    = diff_action(cs_eff, item.cls_a, item.cls_b);
	assign da     = (item.cls_a != BC_OTHER);
	assign db     = (item.cls_b != BC_OTHER);

	// next state
	always_comb begin
		phase_d   = phase_q;
		class_d   = class_q;
		save_diff = 1'b0;
		if (pop) begin
			phase_d = ph_eff;
			class_d = cs_eff;
			unique case (ph_eff)
				PH_CMP: begin
					if (item.diff == '0) begin
						if (item.a_zero) begin
							phase_d = PH_IDLE;
						end else begin
							class_d = next_class(cs_eff, item.cls_a);
						end
					end else if (act == ACT_LEN) begin
						phase_d   = PH_LEN;
						save_diff = 1'b1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_LEN: begin
					if (!(da && db)) begin
						phase_d = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// outputs
	always_comb begin
		emit       = 1'b0;
		emit_value = '0;
		unique case (ph_eff)
			PH_CMP: begin
				if (item.diff == '0) begin
					emit = item.a_zero;
				end else begin
					unique case (act)
						ACT_CMP: begin
							emit       = 1'b1;
							emit_value = item.diff;
						end
						ACT_PLUS: begin
							emit       = 1'b1;
							emit_value = 9'sd1;
						end
						ACT_MINUS: begin
							emit       = 1'b1;
							emit_value = -9'sd1;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			PH_LEN: begin
				emit = !(da && db);
				if (da) begin
					emit_value = 9'sd1;
				end else if (db) begin
					emit_value = -9'sd1;
				end else begin
					emit_value = saved_diff_q;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			class_q       <= CS_NORMAL;
			saved_diff_q  <= '0;
			order_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			class_q <= class_d;
			if (save_diff) begin
				saved_diff_q <= item.diff;
			end
			if (pop && emit) begin
				order_valid_q <= 1'b1;
			end else if (order_ch.ready) begin
				order_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			order_q <= emit_value;
		end
	end

	assign order_ch.valid = order_valid_q;
	assign order_ch.order = order_q;

`ifndef NO_ASSERTIONS
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !item.start && phase_q == PH_IDLE) |-> !emit)
		else $error("result from a pair outside any comparison");

	a_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (phase_q == PH_IDLE))
		else $error("comparison still running after its result");

	a_len_saved: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEN) |-> (saved_diff_q != '0))
		else $error("length phase entered without a byte difference");
`endif

endmodule

`default_nettype wire

### rtl/core/version_string_compare_unit.sv
// ----------------------------------------------------------------------------
// version_string_compare_unit: version-order string comparator
// Compares two strings fed one aligned byte pair per beat, terminators
// included, and returns one signed order per comparison.
// ----------------------------------------------------------------------------
// pair_ch carries byte_a, byte_b and start_pair; a beat with start_pair set
// opens a new comparison and drops any running one without a result. Beats
// outside a comparison are taken and ignored.
// order_ch carries one beat per finished comparison: negative if the first
// string sorts before the second, zero if equal, positive if after.
// Throughput is one pair per cycle unless the receiver stalls a held beat:
// the classifier pushes into a queue of QUEUE_DEPTH entries and the engine
// drains one entry per cycle. A pair that decides a comparison passes the
// queue register and then the output register on its way to order_ch.
// Reset clears the queue, the engine state and the output valid; the block
// takes pairs from the first cycle after reset.
// When the receiver stalls, the output register holds its beat, the engine
// halts and the queue fills; pair_ch.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module version_string_compare_unit
	import vsc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	vsc_in_if.sink      pair_ch,
	vsc_out_if.source   order_ch
);

	logic        push;
	pair_info_t  push_info;
	logic        queue_full;
	logic        pop;
	pair_info_t  pop_info;
	logic        queue_not_empty;

	vsc_front u_front (
		.pair_ch    (pair_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_info  (push_info)
	);

	vsc_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_info (push_info),
		.full      (queue_full),
		.pop       (pop),
		.pop_info  (pop_info),
		.not_empty (queue_not_empty)
	);

	vsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_not_empty),
		.item       (pop_info),
		.pop        (pop),
		.order_ch   (order_ch)
	);

endmodule

`default_nettype wire

### sim/tb_version_string_compare_unit.sv
// ----------------------------------------------------------------------------
// tb_version_string_compare_unit: self-checking bench for the version
// string comparator
// Feeds byte pairs on pair_ch and checks every order beat on order_ch
// against an in-bench model of the version-order comparison, or against a
// fixed order for some rows of a short table of directed pairs, which comes
// first. Random string pairs follow, built to share prefixes and digit runs,
// mixed with abandoned starts and idle noise. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_version_string_compare_unit;
	import vsc_pkg::*;

	localparam int RANDOM_PAIRS = 1700;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0]        a;
		logic [7:0]        b;
		logic              start;
		logic              fixed;
		logic signed [8:0] order;
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n;

	vsc_in_if  pair_if ();
	vsc_out_if order_if ();

	version_string_compare_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair_ch  (pair_if),
		.order_ch (order_if)
	);

	phase_t            cmp_phase;
	class_state_t      cmp_class;
	logic signed [8:0] held_diff;

	logic signed [8:0] pending_orders [$];
	logic              gaps_on;
	int                mismatch_count;
	int                pairs_fed;
	int                comparisons_opened;
	int                orders_checked;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic byte_class_t kind_of(input logic [7:0] c);
		if (c == CHAR_ZERO) begin
			return BC_ZERO;
		end
		if (c > CHAR_ZERO && c <= CHAR_NINE) begin
			return BC_DIGIT;
		end
		return BC_OTHER;
	endfunction

	function automatic class_state_t class_after(input class_state_t cs, input byte_class_t k);
		class_state_t r;
		case (k)
			BC_OTHER: r = CS_NORMAL;
			BC_DIGIT: r = (cs == CS_NORMAL || cs == CS_INTEGER) ? CS_INTEGER : CS_FRACTION;
			default:  r = (cs == CS_NORMAL) ? CS_LEADZ : cs;
		endcase
		return r;
	endfunction

	function automatic action_t first_diff_rule(input class_state_t cs, input byte_class_t ka,
		input byte_class_t kb);
		action_t r;
		r = ACT_CMP;
		case (cs)
			CS_NORMAL: begin
				if (ka == BC_DIGIT && kb == BC_DIGIT) begin
					r = ACT_LEN;
				end
			end
			CS_INTEGER: begin
				if (ka == BC_OTHER) begin
					r = (kb == BC_OTHER) ? ACT_CMP : ACT_MINUS;
				end else begin
					r = (kb == BC_OTHER) ? ACT_PLUS : ACT_LEN;
				end
			end
			CS_LEADZ: begin
				if (ka == BC_OTHER) begin
					r = (kb == BC_OTHER) ? ACT_CMP : ACT_PLUS;
				end else begin
					r = (kb == BC_OTHER) ? ACT_MINUS : ACT_CMP;
				end
			end
			default: r = ACT_CMP;
		endcase
		return r;
	endfunction

	task automatic version_order_step(input logic [7:0] a, input logic [7:0] b, input logic s,
		output logic done, output logic signed [8:0] order);
		logic signed [8:0] diff;
		byte_class_t       ka;
		byte_class_t       kb;
		action_t           act;
		diff  = $signed({1'b0, a}) - $signed({1'b0, b});
		ka    = kind_of(a);
		kb    = kind_of(b);
		done  = 1'b0;
		order = '0;
		if (s) begin
			cmp_phase = PH_CMP;
			cmp_class = CS_NORMAL;
		end
		case (cmp_phase)
			PH_CMP: begin
				if (diff == 0) begin
					if (a == 8'h00) begin
						cmp_phase = PH_IDLE;
						done      = 1'b1;
					end else begin
						cmp_class = class_after(cmp_class, ka);
					end
				end else begin
					act = first_diff_rule(cmp_class, ka, kb);
					case (act)
						ACT_LEN: begin
							held_diff = diff;
							cmp_phase = PH_LEN;
						end
						ACT_PLUS: begin
							order = 9'sd1;
						end
						ACT_MINUS: begin
							order = -9'sd1;
						end
						default: begin
							order = diff;
						end
					endcase
					if (act != ACT_LEN) begin
						cmp_phase = PH_IDLE;
						done      = 1'b1;
					end
				end
			end
			PH_LEN: begin
				if (ka == BC_OTHER || kb == BC_OTHER) begin
					cmp_phase = PH_IDLE;
					done      = 1'b1;
					if (ka != BC_OTHER) begin
						order = 9'sd1;
					end else if (kb != BC_OTHER) begin
						order = -9'sd1;
					end else begin
						order = held_diff;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic s,
		input logic fixed, input logic signed [8:0] fixed_order);
		logic              done;
		logic signed [8:0] order;
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			pair_if.valid <= 1'b0;
			@(negedge clk);
		end
		pair_if.valid      <= 1'b1;
		pair_if.byte_a     <= a;
		pair_if.byte_b     <= b;
		pair_if.start_pair <= s;
		do @(posedge clk); while (!pair_if.ready);
		version_order_step(a, b, s, done, order);
		if (done || fixed) begin
			pending_orders.push_back(fixed ? fixed_order : order);
		end
		pairs_fed++;
		if (s) begin
			comparisons_opened++;
		end
	endtask

	task automatic drain_orders();
		@(negedge clk);
		pair_if.valid <= 1'b0;
		while (pending_orders.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic flag_mismatch(input string why, input logic signed [8:0] want,
		input logic signed [8:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("order mismatch at %0t: %s, expected %0d, got %0d", $time, why, want, got);
		end
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			return 8'($urandom_range(8'h31, 8'h39));
		end
		if (r < 50) begin
			return CHAR_ZERO;
		end
		if (r < 65) begin
			return 8'h2E;
		end
		if (r < 85) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	always @(negedge clk) begin
		order_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		if (arst_n && order_if.valid && order_if.ready) begin
			if (pending_orders.size() == 0) begin
				flag_mismatch("beat with nothing expected", '0, order_if.order);
			end else if (order_if.order !== pending_orders[0]) begin
				flag_mismatch("wrong order value", pending_orders[0], order_if.order);
				void'(pending_orders.pop_front());
			end else begin
				void'(pending_orders.pop_front());
			end
			orders_checked++;
		end
	end

	initial begin
		pair_row_t   steps [0:24];
		logic [7:0]  str_a [0:15];
		logic [7:0]  str_b [0:15];
		int          live_pairs;
		int          cmp_index;
		int          mode;
		int          limit;
		int          len_a;
		int          len_b;
		int          p;
		int          i;
		logic        flip;
		logic        s;
		logic [7:0]  a;
		logic [7:0]  b;

		arst_n             = 1'b0;
		pair_if.valid      = 1'b0;
		pair_if.byte_a     = 8'h00;
		pair_if.byte_b     = 8'h00;
		pair_if.start_pair = 1'b0;
		order_if.ready     = 1'b0;
		gaps_on            = 1'b1;
		cmp_phase          = PH_IDLE;
		cmp_class          = CS_NORMAL;
		held_diff          = '0;
		mismatch_count     = 0;
		pairs_fed          = 0;
		comparisons_opened = 0;
		orders_checked     = 0;

		steps = '{
			'{8'hFF, 8'h00, 1'b0, 1'b0, 9'sd0},
			'{8'h00, 8'h00, 1'b1, 1'b1, 9'sd0},
			'{8'hFF, 8'h00, 1'b1, 1'b1, 9'sd255},
			'{8'h00, 8'hFF, 1'b1, 1'b1, -9'sd255},
			'{8'h31, 8'h31, 1'b1, 1'b0, 9'sd0},
			'{8'h2E, 8'h2E, 1'b0, 1'b0, 9'sd0},
			'{8'h30, 8'h30, 1'b0, 1'b0, 9'sd0},
			'{8'h00, 8'h00, 1'b0, 1'b1, 9'sd0},
			'{8'h61, 8'h61, 1'b1, 1'b0, 9'sd0},
			'{8'h41, 8'h42, 1'b1, 1'b1, -9'sd1},
			'{8'h31, 8'h31, 1'b1, 1'b0, 9'sd0},
			'{8'h32, 8'h33, 1'b0, 1'b0, 9'sd0},
			'{8'h00, 8'h78, 1'b0, 1'b0, 9'sd0},
			'{8'h39, 8'h31, 1'b1, 1'b0, 9'sd0},
			'{8'h35, 8'h00, 1'b0, 1'b0, 9'sd0},
			'{8'h32, 8'h35, 1'b1, 1'b0, 9'sd0},
			'{8'h30, 8'h30, 1'b0, 1'b0, 9'sd0},
			'{8'h2E, 8'h39, 1'b0, 1'b0, 9'sd0},
			'{8'h31, 8'h31, 1'b1, 1'b0, 9'sd0},
			'{8'h32, 8'h2E, 1'b0, 1'b0, 9'sd0},
			'{8'h30, 8'h30, 1'b1, 1'b0, 9'sd0},
			'{8'h35, 8'h2E, 1'b0, 1'b0, 9'sd0},
			'{8'h30, 8'h30, 1'b1, 1'b0, 9'sd0},
			'{8'h31, 8'h31, 1'b0, 1'b0, 9'sd0},
			'{8'h32, 8'h33, 1'b0, 1'b0, 9'sd0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (steps[k]) begin
			send_pair(steps[k].a, steps[k].b, steps[k].start, steps[k].fixed, steps[k].order);
		end
		drain_orders();

		live_pairs = 0;
		cmp_index  = 0;
		while (live_pairs < RANDOM_PAIRS) begin
			cmp_index++;
			gaps_on = !(cmp_index >= 60 && cmp_index < 110);
			if (cmp_index % 150 == 0) begin
				drain_orders();
			end
			mode = $urandom_range(0, 99);
			if (mode < 10) begin
				// idle noise, or stray pairs into an abandoned comparison
				repeat ($urandom_range(1, 4)) begin
					a = 8'($urandom_range(0, 255));
					b = ($urandom_range(0, 3) == 0) ? a : 8'($urandom_range(0, 255));
					s = ($urandom_range(0, 9) == 0);
					if (s || cmp_phase != PH_IDLE) begin
						live_pairs++;
					end
					send_pair(a, b, s, 1'b0, '0);
				end
			end else begin
				for (i = 0; i < 16; i++) begin
					str_a[i] = 8'h00;
				end
				len_a = $urandom_range(0, 10);
				for (i = 0; i < len_a; i++) begin
					str_a[i] = pick_char();
				end
				str_b = str_a;
				case ($urandom_range(0, 4))
					1: begin
						p        = $urandom_range(0, len_a);
						str_b[p] = pick_char();
					end
					2: begin
						p     = $urandom_range(0, len_a);
						len_b = $urandom_range(p + 1, 12);
						for (i = p; i < 16; i++) begin
							str_b[i] = (i < len_b) ? pick_char() : 8'h00;
						end
					end
					3: begin
						len_b = $urandom_range(0, len_a);
						for (i = len_b; i < 16; i++) begin
							str_b[i] = 8'h00;
						end
					end
					4: begin
						len_b = $urandom_range(0, 10);
						for (i = 0; i < 16; i++) begin
							str_b[i] = (i < len_b) ? pick_char() : 8'h00;
						end
					end
					default: ;
				endcase
				flip  = 1'($urandom_range(0, 1));
				limit = (mode < 22) ? $urandom_range(1, 3) : 16;
				for (i = 0; i < limit; i++) begin
					send_pair(flip ? str_b[i] : str_a[i], flip ? str_a[i] : str_b[i],
						i == 0, 1'b0, '0);
					live_pairs++;
					if (cmp_phase == PH_IDLE) begin
						break;
					end
				end
			end
		end

		drain_orders();
		repeat (10) @(posedge clk);
		if (pending_orders.size() != 0) begin
			mismatch_count += pending_orders.size();
			$display("%0d expected orders never arrived", pending_orders.size());
		end

		$display("Ran %0d comparisons over %0d pairs, %0d order beats checked,",
			comparisons_opened, pairs_fed, orders_checked);
		$display("with abandoned starts, idle pairs, digit runs and stalls on both sides.");
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
